[rtl/linear_prime_sieve_core_assert.svh]
// Assertion macros used by the checker file of the prime sieve core.
`ifndef LINEAR_PRIME_SIEVE_CORE_ASSERT_SVH
`define LINEAR_PRIME_SIEVE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define LPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define LPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lps_pkg.sv]
// Package of the prime sieve core: sizes, constants, state codes and control structs.
package lps_pkg;

    // Storage sizes
    localparam int LIMIT_MAX        = 16384;
    localparam int PRIME_LIST_DEPTH = 2048;

    // Derived widths
    localparam int MAP_AW  = $clog2(LIMIT_MAX);            // map index, prime value
    localparam int LIST_AW = $clog2(PRIME_LIST_DEPTH);     // prime list index
    localparam int CNT_W   = 12;                           // prime count port
    localparam int CAND_W  = 15;                           // candidate / number port
    localparam int CFG_W   = 15;                           // limit register
    localparam int SIG_W   = 21;                           // digit signature port
    localparam int PROD_W  = 2 * MAP_AW;                   // candidate times prime
    localparam int REM_CW  = $clog2(MAP_AW + 1);           // remainder step counter

    // Constants
    localparam int LIMIT_RESET = 16384;
    localparam int FIRST_CAND  = 2;
    localparam int DIV10_MUL   = 52429;                    // x/10 = (x*52429)>>19
    localparam int DIV10_SH    = 19;
    localparam int DIGIT_W     = 4;

    // Controller states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_TEST,
        S_CHECK,
        S_LRD,
        S_LMUL,
        S_LCMP,
        S_LMOD,
        S_RESULT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic restart;
        logic clear_step;
        logic test;
        logic check;
        logic mul;
        logic mark;
        logic j_inc;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic at_limit;
        logic map_marked;
        logic j_end;
        logic prod_at_limit;
        logic rem_busy;
        logic rem_zero;
        logic sig_busy;
    } t_dp_status;

endpackage

[rtl/lps_mod.sv]
// Restoring remainder unit: one dividend bit per cycle, flags a zero remainder.
module lps_mod (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [lps_pkg::MAP_AW-1:0] i_dividend,
    input  logic [lps_pkg::MAP_AW-1:0] i_divisor,
    output logic                      o_busy,
    output logic                      o_zero
);

    logic [lps_pkg::MAP_AW-1:0] r_rem;
    logic [lps_pkg::MAP_AW-1:0] r_dvd;
    logic [lps_pkg::MAP_AW-1:0] r_div;
    logic [lps_pkg::REM_CW-1:0] r_cnt;
    logic [lps_pkg::MAP_AW:0]   w_trial;
    logic [lps_pkg::MAP_AW:0]   w_diff;
    logic [lps_pkg::MAP_AW-1:0] n_rem;

    // Shift in the next dividend bit, subtract when it fits
    always_comb begin
        w_trial = {r_rem, r_dvd[lps_pkg::MAP_AW-1]};
        w_diff  = w_trial - {1'b0, r_div};
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = w_diff[lps_pkg::MAP_AW-1:0];
        end else begin
            n_rem = w_trial[lps_pkg::MAP_AW-1:0];
        end
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= lps_pkg::REM_CW'(lps_pkg::MAP_AW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[lps_pkg::MAP_AW-2:0], 1'b0};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_zero = (r_rem == '0);

endmodule

[rtl/lps_dsig.sv]
// Decimal digit signature: one digit per cycle via a reciprocal multiply by ten.
module lps_dsig (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lps_pkg::MAP_AW-1:0] i_value,
    output logic                       o_busy,
    output logic [lps_pkg::SIG_W-1:0]  o_sig
);

    localparam int PW = lps_pkg::MAP_AW + lps_pkg::DIV10_SH;

    logic [lps_pkg::MAP_AW-1:0]  r_v;
    logic [lps_pkg::SIG_W-1:0]   r_sig;
    logic [PW-1:0]               w_prod;
    logic [lps_pkg::MAP_AW-1:0]  w_q;
    logic [lps_pkg::MAP_AW-1:0]  w_low;
    logic [lps_pkg::DIGIT_W-1:0] w_d;

    // Quotient and low digit of the remaining value
    always_comb begin
        w_prod = PW'(r_v) * PW'(lps_pkg::DIV10_MUL);
        w_q    = w_prod[lps_pkg::DIV10_SH +: lps_pkg::MAP_AW];
        w_low  = r_v - (w_q << 3) - (w_q << 1);
        w_d    = w_low[lps_pkg::DIGIT_W-1:0];
    end

    // Remaining value; zero means finished
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_start) begin
            r_v <= i_value;
        end else if (r_v != '0) begin
            r_v <= w_q;
        end
    end

    // Signature accumulator
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sig <= '0;
        end else if (r_v != '0) begin
            r_sig <= r_sig + (lps_pkg::SIG_W'(1) << {w_d, 1'b0});
        end
    end

    assign o_busy = (r_v != '0);
    assign o_sig  = r_sig;

endmodule

[rtl/lps_dp.sv]
// Sieve datapath: composite map, prime list, candidate, product, output registers.
module lps_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lps_pkg::t_dp_cmd            i_cmd,
    output lps_pkg::t_dp_status         o_status,
    input  logic                        i_cfg_valid,
    input  logic [lps_pkg::CFG_W-1:0]   i_cfg_limit,
    output logic [lps_pkg::CAND_W-1:0]  o_number,
    output logic                        o_is_prime,
    output logic [lps_pkg::CNT_W-1:0]   o_prime_count,
    output logic [lps_pkg::SIG_W-1:0]   o_digit_signature,
    output logic                        o_done_res
);

    localparam int CMP_W = lps_pkg::CFG_W + 2;

    // Memories
    logic                       r_map_mem  [lps_pkg::LIMIT_MAX];
    logic [lps_pkg::MAP_AW-1:0] r_list_mem [lps_pkg::PRIME_LIST_DEPTH];

    logic [lps_pkg::CFG_W-1:0]  r_limit;
    logic [lps_pkg::CAND_W-1:0] r_next;
    logic [lps_pkg::CNT_W-1:0]  r_total;
    logic [lps_pkg::CNT_W-1:0]  r_j;
    logic [lps_pkg::MAP_AW-1:0] r_clr_addr;
    logic                       r_map_q;
    logic [lps_pkg::MAP_AW-1:0] r_list_q;
    logic [lps_pkg::PROD_W-1:0] r_prod;
    logic                       r_done;
    logic                       r_is_prime;

    logic [lps_pkg::CAND_W-1:0] r_number;
    logic                       r_out_prime;
    logic [lps_pkg::CNT_W-1:0]  r_count;
    logic [lps_pkg::SIG_W-1:0]  r_sig;
    logic                       r_out_done;

    logic [lps_pkg::CAND_W-1:0] w_eff;
    logic                       w_at_limit;
    logic                       w_map_we;
    logic [lps_pkg::MAP_AW-1:0] w_map_addr;
    logic                       w_room;
    logic                       w_new_prime;
    logic                       w_rem_busy;
    logic                       w_rem_zero;
    logic                       w_sig_busy;
    logic [lps_pkg::SIG_W-1:0]  w_sig;

    // Effective limit, capped at the map size
    always_comb begin
        if (CMP_W'(r_limit) > CMP_W'(lps_pkg::LIMIT_MAX)) begin
            w_eff = lps_pkg::CAND_W'(lps_pkg::LIMIT_MAX);
        end else begin
            w_eff = lps_pkg::CAND_W'(r_limit);
        end
        w_at_limit  = (r_next >= w_eff);
        w_room      = (r_total < lps_pkg::CNT_W'(lps_pkg::PRIME_LIST_DEPTH));
        w_new_prime = !r_map_q;
        w_map_we    = i_cmd.clear_step | i_cmd.mark;
        w_map_addr  = i_cmd.clear_step ? r_clr_addr : r_prod[lps_pkg::MAP_AW-1:0];
    end

    // Limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= lps_pkg::CFG_W'(lps_pkg::LIMIT_RESET);
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_limit;
        end
    end

    // Candidate, prime total, clear sweep address, list walk index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next     <= lps_pkg::CAND_W'(lps_pkg::FIRST_CAND);
            r_total    <= '0;
            r_clr_addr <= '0;
            r_j        <= '0;
        end else begin
            if (i_cmd.restart) begin
                r_next     <= lps_pkg::CAND_W'(lps_pkg::FIRST_CAND);
                r_total    <= '0;
                r_clr_addr <= '0;
            end else begin
                if (i_cmd.clear_step) begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
                if (i_cmd.check && w_new_prime && w_room) begin
                    r_total <= r_total + 1'b1;
                end
                if (i_cmd.load_out && !r_done) begin
                    r_next <= r_next + 1'b1;
                end
            end
            if (i_cmd.check) begin
                r_j <= '0;
            end else if (i_cmd.j_inc) begin
                r_j <= r_j + 1'b1;
            end
        end
    end

    // Composite map: one write port, candidate read port
    always_ff @(posedge i_clk) begin
        if (w_map_we) begin
            r_map_mem[w_map_addr] <= !i_cmd.clear_step;
        end
        r_map_q <= r_map_mem[r_next[lps_pkg::MAP_AW-1:0]];
    end

    // Prime list: append at the total, read at the walk index
    always_ff @(posedge i_clk) begin
        if (i_cmd.check && w_new_prime && w_room) begin
            r_list_mem[r_total[lps_pkg::LIST_AW-1:0]] <= r_next[lps_pkg::MAP_AW-1:0];
        end
        r_list_q <= r_list_mem[r_j[lps_pkg::LIST_AW-1:0]];
    end

    // Step flags and product
    always_ff @(posedge i_clk) begin
        if (i_cmd.test) begin
            r_done     <= w_at_limit;
            r_is_prime <= 1'b0;
        end else if (i_cmd.check) begin
            r_is_prime <= w_new_prime;
        end
        if (i_cmd.mul) begin
            r_prod <= lps_pkg::PROD_W'(r_next[lps_pkg::MAP_AW-1:0]) *
                      lps_pkg::PROD_W'(r_list_q);
        end
    end

    // Result beat registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_number    <= r_next;
            r_out_prime <= r_is_prime & !r_done;
            r_count     <= r_total;
            r_sig       <= (r_is_prime & !r_done) ? w_sig : '0;
            r_out_done  <= r_done;
        end
    end

    lps_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mul),
        .i_dividend (r_next[lps_pkg::MAP_AW-1:0]),
        .i_divisor  (r_list_q),
        .o_busy     (w_rem_busy),
        .o_zero     (w_rem_zero)
    );

    lps_dsig u_dsig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.test & !w_at_limit),
        .i_value (r_next[lps_pkg::MAP_AW-1:0]),
        .o_busy  (w_sig_busy),
        .o_sig   (w_sig)
    );

    // Status back to the controller
    always_comb begin
        o_status.clr_last = (r_clr_addr == lps_pkg::MAP_AW'(lps_pkg::LIMIT_MAX - 1));
        o_status.at_limit      = w_at_limit;
        o_status.map_marked    = r_map_q;
        o_status.j_end         = (r_j >= r_total);
        o_status.prod_at_limit = (r_prod >= lps_pkg::PROD_W'(w_eff));
        o_status.rem_busy      = w_rem_busy;
        o_status.rem_zero      = w_rem_zero;
        o_status.sig_busy      = w_sig_busy;
    end

    assign o_number          = r_number;
    assign o_is_prime        = r_out_prime;
    assign o_prime_count     = r_count;
    assign o_digit_signature = r_sig;
    assign o_done_res        = r_out_done;

endmodule

[rtl/lps_ctrl.sv]
// Sieve controller: map clear sweep, candidate test, prime list walk, result handoff.
module lps_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_restart,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  lps_pkg::t_dp_status i_status,
    output lps_pkg::t_dp_cmd    o_cmd
);

    lps_pkg::t_state r_state;
    lps_pkg::t_state n_state;
    logic            r_pending;
    logic            n_pending;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lps_pkg::S_CLEAR;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state
    always_comb begin
        n_state   = r_state;
        n_pending = r_pending;
        unique case (r_state)
            lps_pkg::S_CLEAR: begin
                if (i_status.clr_last) begin
                    n_state   = r_pending ? lps_pkg::S_TEST : lps_pkg::S_IDLE;
                    n_pending = 1'b0;
                end
            end
            lps_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_restart) begin
                        n_state   = lps_pkg::S_CLEAR;
                        n_pending = 1'b1;
                    end else begin
                        n_state = lps_pkg::S_TEST;
                    end
                end
            end
            lps_pkg::S_TEST: begin
                n_state = i_status.at_limit ? lps_pkg::S_RESULT : lps_pkg::S_CHECK;
            end
            lps_pkg::S_CHECK: begin
                n_state = lps_pkg::S_LRD;
            end
            lps_pkg::S_LRD: begin
                n_state = i_status.j_end ? lps_pkg::S_RESULT : lps_pkg::S_LMUL;
            end
            lps_pkg::S_LMUL: begin
                n_state = lps_pkg::S_LCMP;
            end
            lps_pkg::S_LCMP: begin
                n_state = i_status.prod_at_limit ? lps_pkg::S_RESULT : lps_pkg::S_LMOD;
            end
            lps_pkg::S_LMOD: begin
                if (!i_status.rem_busy) begin
                    n_state = i_status.rem_zero ? lps_pkg::S_RESULT : lps_pkg::S_LRD;
                end
            end
            lps_pkg::S_RESULT: begin
                if (!i_status.sig_busy && w_slot_free) begin
                    n_state = lps_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lps_pkg::S_CLEAR;
            end
        endcase
    end

    // Outputs and datapath commands
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            lps_pkg::S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
            end
            lps_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.restart = i_in_valid && i_restart;
            end
            lps_pkg::S_TEST: begin
                o_cmd.test = 1'b1;
            end
            lps_pkg::S_CHECK: begin
                o_cmd.check = 1'b1;
            end
            lps_pkg::S_LRD: begin
            end
            lps_pkg::S_LMUL: begin
                o_cmd.mul = 1'b1;
            end
            lps_pkg::S_LCMP: begin
                o_cmd.mark = !i_status.prod_at_limit;
            end
            lps_pkg::S_LMOD: begin
                o_cmd.j_inc = !i_status.rem_busy && !i_status.rem_zero;
            end
            lps_pkg::S_RESULT: begin
                if (!i_status.sig_busy && w_slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

[rtl/linear_prime_sieve_core.sv]
// Top level of the linear prime sieve core: controller, datapath, config ready.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------------
//   in      | sink      | i_in_valid / o_in_ready | i_restart
//   out     | source    | o_out_valid/i_out_ready | o_number, o_is_prime,
//           |           |                         | o_prime_count, o_digit_signature,
//           |           |                         | o_done_res
//   cfg     | sink      | i_cfg_valid/o_cfg_ready | i_cfg_limit
//
// A candidate at or past the limit goes straight to the result; otherwise each walked
// prime waits on the one-bit-per-cycle remainder unit.
// After reset and after each restart beat the composite map is swept clear
// while the in channel is not ready; cfg beats are always taken.
// The next in beat is taken while a result beat still waits in the output register.
module linear_prime_sieve_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_restart,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [lps_pkg::CAND_W-1:0]  o_number,
    output logic                        o_is_prime,
    output logic [lps_pkg::CNT_W-1:0]   o_prime_count,
    output logic [lps_pkg::SIG_W-1:0]   o_digit_signature,
    output logic                        o_done_res,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lps_pkg::CFG_W-1:0]   i_cfg_limit
);

    lps_pkg::t_dp_cmd    w_cmd;
    lps_pkg::t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    lps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_restart   (i_restart),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    lps_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_limit       (i_cfg_limit),
        .o_number          (o_number),
        .o_is_prime        (o_is_prime),
        .o_prime_count     (o_prime_count),
        .o_digit_signature (o_digit_signature),
        .o_done_res        (o_done_res)
    );

endmodule

[rtl/lps_checker.sv]
// Port-level checker of the prime sieve core and its bind to the top level.
`include "linear_prime_sieve_core_assert.svh"

module lps_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [lps_pkg::CAND_W-1:0]  o_number,
    input logic                        o_is_prime,
    input logic [lps_pkg::CNT_W-1:0]   o_prime_count,
    input logic [lps_pkg::SIG_W-1:0]   o_digit_signature,
    input logic                        o_done_res
);

    // A done beat reports nothing tested
    `LPS_ASSERT_IMP(a_done_quiet, i_clk, i_rst_n, o_out_valid && o_done_res, !o_is_prime && o_digit_signature == '0, "done beat reports a prime or a signature")

    // Only primes carry a signature
    `LPS_ASSERT_IMP(a_sig_prime_only, i_clk, i_rst_n, o_out_valid && !o_is_prime, o_digit_signature == '0, "signature on a non-prime beat")

    // A prime beat counts itself and has a nonzero signature
    `LPS_ASSERT_IMP(a_prime_counted, i_clk, i_rst_n, o_out_valid && o_is_prime, o_prime_count != '0 && o_digit_signature != '0 && o_number >= lps_pkg::CAND_W'(lps_pkg::FIRST_CAND), "prime beat with zero count or signature")

    // A stalled result beat holds
    `LPS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_number) && $stable(o_prime_count) && $stable(o_done_res), "stalled result beat changed")

endmodule

bind linear_prime_sieve_core lps_checker u_lps_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_number          (o_number),
    .o_is_prime        (o_is_prime),
    .o_prime_count     (o_prime_count),
    .o_digit_signature (o_digit_signature),
    .o_done_res        (o_done_res)
);

[sim/testbench.sv]
// Self-checking testbench of the linear prime sieve core with its own sieve predictor.
module testbench;

    // Expected content of one out beat
    typedef struct packed {
        logic [lps_pkg::CAND_W-1:0] number;
        logic                       is_prime;
        logic [lps_pkg::CNT_W-1:0]  prime_count;
        logic [lps_pkg::SIG_W-1:0]  digit_sig;
        logic                       done;
    } t_sieve_result;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic                       in_restart = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [lps_pkg::CAND_W-1:0] out_number;
    logic                       out_is_prime;
    logic [lps_pkg::CNT_W-1:0]  out_prime_count;
    logic [lps_pkg::SIG_W-1:0]  out_digit_sig;
    logic                       out_done;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [lps_pkg::CFG_W-1:0]  cfg_limit = '0;

    // Stimulus and scoreboard state
    bit            restart_q[$];
    t_sieve_result sieve_results_q[$];
    bit            in_fire_q = 1'b0;
    int unsigned   snd_idle_pct = 37;
    int unsigned   rcv_idle_pct = 77;
    int unsigned   rand_items = 0;
    int unsigned   err_count = 0;

    // Predictor state
    bit            mark_map [lps_pkg::LIMIT_MAX];
    int unsigned   found_primes [lps_pkg::PRIME_LIST_DEPTH];
    int unsigned   found_total;
    int unsigned   cand_ctr;
    int unsigned   limit_reg = lps_pkg::LIMIT_RESET;

    linear_prime_sieve_core u_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_restart         (in_restart),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_number          (out_number),
        .o_is_prime        (out_is_prime),
        .o_prime_count     (out_prime_count),
        .o_digit_signature (out_digit_sig),
        .o_done_res        (out_done),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_limit       (cfg_limit)
    );

    always #5 clk = ~clk;

    // Wipe map, prime list and counters; next candidate is two
    function automatic void clear_sieve();
        foreach (mark_map[i]) mark_map[i] = 1'b0;
        foreach (found_primes[i]) found_primes[i] = 0;
        found_total = 0;
        cand_ctr    = lps_pkg::FIRST_CAND;
    endfunction

    // Sum of 1 << (2*d) over the decimal digits d
    function automatic logic [lps_pkg::SIG_W-1:0] digit_weight_sum(input int unsigned v);
        int unsigned s;
        s = 0;
        while (v != 0) begin
            s += 32'd1 << ((v % 10) * 2);
            v /= 10;
        end
        return s[lps_pkg::SIG_W-1:0];
    endfunction

    // One sieve step: test the next candidate, then mark its multiples
    function automatic t_sieve_result sieve_next(input bit restart);
        t_sieve_result    r;
        int unsigned      eff;
        int unsigned      cand;
        int unsigned      p;
        longint unsigned  prod;
        r = '0;
        if (restart) clear_sieve();
        eff  = (limit_reg > lps_pkg::LIMIT_MAX) ? lps_pkg::LIMIT_MAX : limit_reg;
        cand = cand_ctr;
        if (cand >= eff) begin
            r.done = 1'b1;
        end else begin
            if (!mark_map[cand]) begin
                r.is_prime  = 1'b1;
                r.digit_sig = digit_weight_sum(cand);
                if (found_total < lps_pkg::PRIME_LIST_DEPTH) begin
                    found_primes[found_total] = cand;
                    found_total++;
                end
            end
            for (int j = 0; j < found_total; j++) begin
                p    = found_primes[j];
                prod = longint'(cand) * p;
                if (prod >= eff) break;
                mark_map[int'(prod)] = 1'b1;
                if (p != 0 && cand % p == 0) break;
            end
            cand_ctr = cand + 1;
        end
        r.number      = cand[lps_pkg::CAND_W-1:0];
        r.prime_count = found_total[lps_pkg::CNT_W-1:0];
        return r;
    endfunction

    // In channel: note accepted beats and predict their results
    always @(posedge clk) begin
        in_fire_q = rst_n && in_valid && in_ready;
        if (in_fire_q) sieve_results_q.push_back(sieve_next(in_restart));
    end

    // Driver: present the next restart bit and the receiver's ready
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= rcv_idle_pct);
            if (!in_valid || in_fire_q) begin
                if (restart_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                    in_restart <= restart_q.pop_front();
                    in_valid   <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each out beat with the oldest prediction
    always @(posedge clk) begin
        t_sieve_result e;
        if (rst_n && out_valid && out_ready) begin
            if (sieve_results_q.size() == 0) begin
                $error("unexpected out beat: number %0d", out_number);
                err_count++;
            end else begin
                e = sieve_results_q.pop_front();
                if (out_number !== e.number) begin
                    $error("number: expected %0d, actual %0d", e.number, out_number);
                    err_count++;
                end
                if (out_is_prime !== e.is_prime) begin
                    $error("is_prime: expected %0d, actual %0d", e.is_prime, out_is_prime);
                    err_count++;
                end
                if (out_prime_count !== e.prime_count) begin
                    $error("prime_count: expected %0d, actual %0d",
                           e.prime_count, out_prime_count);
                    err_count++;
                end
                if (out_digit_sig !== e.digit_sig) begin
                    $error("digit_signature: expected %0d, actual %0d",
                           e.digit_sig, out_digit_sig);
                    err_count++;
                end
                if (out_done !== e.done) begin
                    $error("done_res: expected %0d, actual %0d", e.done, out_done);
                    err_count++;
                end
            end
        end
    end

    // Hold the sender until every beat is out and every result is back
    task automatic wait_drained();
        do @(posedge clk);
        while (restart_q.size() != 0 || in_valid || sieve_results_q.size() != 0);
    endtask

    // Write the limit register; only called while the core is idle
    task automatic write_limit(input int unsigned v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_limit <= v[lps_pkg::CFG_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        limit_reg = v & 32'h7FFF;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_restarts(input bit r, input int unsigned n);
        repeat (n) restart_q.push_back(r);
    endtask

    // Mostly small limits so runs reach done; a few extremes
    function automatic int unsigned pick_limit();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) return $urandom_range(120, 3);
        if (r < 85) return $urandom_range(2000, 121);
        if (r < 90) return lps_pkg::LIMIT_MAX;
        if (r < 94) return $urandom_range(32767, lps_pkg::LIMIT_MAX + 1);
        if (r < 97) return $urandom_range(2, 0);
        return 3;
    endfunction

    // One run: restart, a stretch of candidates, maybe a limit change mid-run
    task automatic random_run();
        int unsigned n;
        write_limit(pick_limit());
        restart_q.push_back(1'b1);
        n = $urandom_range(80, 30);
        repeat (n) restart_q.push_back($urandom_range(999) < 7);
        rand_items += n + 1;
        if ($urandom_range(3) == 0) begin
            wait_drained();
            write_limit(pick_limit());
            n = $urandom_range(40, 5);
            queue_restarts(1'b0, n);
            rand_items += n;
        end
        wait_drained();
    endtask

    // Main sequence
    initial begin
        clear_sieve();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset limit, first candidates from two
        queue_restarts(1'b0, 6);
        wait_drained();
        // Limit at two: done, also right after a restart
        write_limit(2);
        queue_restarts(1'b0, 1);
        queue_restarts(1'b1, 1);
        wait_drained();
        write_limit(0);
        queue_restarts(1'b0, 1);
        wait_drained();
        // Smallest useful limit: one prime, then done repeats without advancing
        write_limit(3);
        queue_restarts(1'b1, 1);
        queue_restarts(1'b0, 2);
        wait_drained();
        // Limit above the map size, raised mid-run so old marks stay
        write_limit(32767);
        queue_restarts(1'b0, 4);
        wait_drained();
        write_limit(lps_pkg::LIMIT_MAX);
        queue_restarts(1'b1, 1);
        queue_restarts(1'b0, 5);
        wait_drained();

        // Random runs over the three idle schedules
        while (rand_items < 1250) begin
            if (rand_items >= 833) begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end else if (rand_items >= 417) begin
                snd_idle_pct = 77;
                rcv_idle_pct = 37;
            end
            random_run();
        end

        wait_drained();
        repeat (64) @(posedge clk);
        if (err_count == 0 && sieve_results_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(64'd100_000_000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/lps_pkg.sv
rtl/lps_mod.sv
rtl/lps_dsig.sv
rtl/lps_dp.sv
rtl/lps_ctrl.sv
rtl/linear_prime_sieve_core.sv
rtl/lps_checker.sv
sim/testbench.sv
